### hdl/hslrgba_pkg.sv
// shared types, constants and helpers for the hsl to rgba converter
`timescale 1ns / 1ps

package hslrgba_pkg;

  // width and full-scale value of one 8-bit color channel
  localparam int CHAN_W = 8;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // number of color channels worked out from the hue
  localparam int NUM_CH = 3;

  // channel slots in the per-channel arrays
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [CHAN_W-1:0] chan_t;

  // clamp a 9-bit scaled value to the 0..255 channel range
  function automatic chan_t clamp_chan(input logic [CHAN_W:0] val);
    chan_t res;
    if (val[CHAN_W]) begin
      res = CHAN_MAX;
    end else begin
      res = val[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

### hdl/hslrgba_ifs.sv
// valid/ready channel interfaces for hsl input items and rgba result items
`timescale 1ns / 1ps

interface hsl_in_if #(
  parameter int FRAC_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS-1:0] hue_turn;
  logic [FRAC_BITS:0]   saturation_frac;
  logic [FRAC_BITS:0]   lightness_frac;
  logic [FRAC_BITS:0]   alpha_frac;

  modport source (
    output valid, hue_turn, saturation_frac, lightness_frac, alpha_frac,
    input  ready
  );
  modport sink (
    input  valid, hue_turn, saturation_frac, lightness_frac, alpha_frac,
    output ready
  );
endinterface

interface rgba_out_if
  import hslrgba_pkg::*;
;
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  chan_t alpha_out;

  modport source (
    output valid, red, green, blue, alpha_out,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, alpha_out,
    output ready
  );
endinterface

### hdl/hsl_to_rgba_converter.sv
// hsl to rgba converter: eight-stage pipeline, one item per clock unless stalled
// throughput: one item per cycle; each stage holds one item and moves on when
//   the stage after it is empty or moving, so a stall fills bubbles first
// reset: synchronous rst clears the stage valid bits; data registers keep garbage
`timescale 1ns / 1ps

module hsl_to_rgba_converter
  import hslrgba_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  hsl_in_if.sink        hsl_in,
  rgba_out_if.source    rgba_out
);

  localparam int F    = FRAC_BITS;
  localparam int UW   = F + 1;       // fraction with 1.0 included
  localparam int TW   = F + 2;       // three times a hue
  localparam int XW   = F + 3;       // room for wrap sums and twice a hue
  localparam int PW   = 2 * F + 2;   // products at 2F fraction bits
  localparam int YW   = 2 * F + 10;  // scaled by 255 plus rounding
  localparam int GW   = F + 9;       // fraction times 255
  localparam int NSTG = 8;

  localparam logic [UW-1:0] ONE_U   = {1'b1, {F{1'b0}}};
  localparam logic [XW-1:0] ONE_X   = {3'b001, {F{1'b0}}};
  localparam logic [XW-1:0] TWO_X   = {3'b010, {F{1'b0}}};
  localparam logic [XW-1:0] THREE_X = {3'b011, {F{1'b0}}};
  localparam logic [XW-1:0] FOUR_X  = {3'b100, {F{1'b0}}};
  localparam logic [PW-1:0] HALF_Q  = PW'(ONE_U >> 1);
  localparam logic [YW-1:0] HALF_Y  = {{(YW-2*F){1'b0}}, 1'b1, {(2*F-1){1'b0}}};

  // stage valid bits and per-stage advance enables
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || rgba_out.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign hsl_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= hsl_in.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: register hue, saturate fractions to 1.0
  logic [F-1:0]  s1_hue;
  logic [UW-1:0] s1_sat, s1_lit, s1_alp;
  logic [UW-1:0] sat_c, lit_c, alp_c;

  always_comb begin
    sat_c = (hsl_in.saturation_frac > ONE_U) ? ONE_U : hsl_in.saturation_frac;
    lit_c = (hsl_in.lightness_frac > ONE_U) ? ONE_U : hsl_in.lightness_frac;
    alp_c = (hsl_in.alpha_frac > ONE_U) ? ONE_U : hsl_in.alpha_frac;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_hue <= hsl_in.hue_turn;
      s1_sat <= sat_c;
      s1_lit <= lit_c;
      s1_alp <= alp_c;
    end
  end

  // stage 2: channel hues as 3*hue, l*s product, gray and alpha scaling
  logic [NUM_CH-1:0][TW-1:0] s2_t3;
  logic [UW-1:0]             s2_sat, s2_lit;
  logic [PW-1:0]             s2_ls;
  chan_t                     s2_gray, s2_alp;
  logic                      s2_gray_en;

  logic [XW-1:0]             h3_c, tr_c, tb_c;
  logic [GW-1:0]             gray_p, alp_p;

  always_comb begin
    h3_c = XW'(s1_hue) + (XW'(s1_hue) << 1);
    tr_c = h3_c + ONE_X;
    if (tr_c >= THREE_X) begin
      tr_c = tr_c - THREE_X;
    end
    tb_c = h3_c + TWO_X;
    if (tb_c >= THREE_X) begin
      tb_c = tb_c - THREE_X;
    end
    gray_p = GW'(s1_lit) * GW'(CHAN_MAX);
    alp_p  = GW'(s1_alp) * GW'(CHAN_MAX);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_t3[CH_RED]   <= tr_c[TW-1:0];
      s2_t3[CH_GREEN] <= h3_c[TW-1:0];
      s2_t3[CH_BLUE]  <= tb_c[TW-1:0];
      s2_sat          <= s1_sat;
      s2_lit          <= s1_lit;
      s2_ls           <= PW'(s1_lit) * PW'(s1_sat);
      s2_gray         <= clamp_chan(gray_p[GW-1:F]);
      s2_alp          <= clamp_chan(alp_p[GW-1:F]);
      s2_gray_en      <= (s1_sat == '0);
    end
  end

  // stage 3: slope multiplier per channel, q at 2F fraction bits
  logic [NUM_CH-1:0][UW-1:0] s3_m;
  logic [PW-1:0]             s3_q2;
  logic [UW-1:0]             s3_lit;
  chan_t                     s3_gray, s3_alp;
  logic                      s3_gray_en;

  logic [NUM_CH-1:0][UW-1:0] m_c;
  logic [XW-1:0]             tt, fall;
  logic [PW-1:0]             q2_c;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      tt   = {s2_t3[c], 1'b0};
      fall = FOUR_X - tt;
      if (tt < ONE_X) begin
        // rising edge
        m_c[c] = tt[UW-1:0];
      end else if (tt < THREE_X) begin
        // flat top at q
        m_c[c] = ONE_U;
      end else if (XW'(s2_t3[c]) < TWO_X) begin
        // falling edge
        m_c[c] = fall[UW-1:0];
      end else begin
        // flat bottom at p
        m_c[c] = '0;
      end
    end
    if (s2_lit[F:F-1] == 2'b00) begin
      q2_c = (PW'(s2_lit) << F) + s2_ls;
    end else begin
      q2_c = ((PW'(s2_lit) + PW'(s2_sat)) << F) - s2_ls;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_m       <= m_c;
      s3_q2      <= q2_c;
      s3_lit     <= s2_lit;
      s3_gray    <= s2_gray;
      s3_alp     <= s2_alp;
      s3_gray_en <= s2_gray_en;
    end
  end

  // stage 4: round q to F fraction bits
  logic [NUM_CH-1:0][UW-1:0] s4_m;
  logic [UW-1:0]             s4_q, s4_lit;
  chan_t                     s4_gray, s4_alp;
  logic                      s4_gray_en;
  logic [PW-1:0]             qr_c;

  assign qr_c = s3_q2 + HALF_Q;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_m       <= s3_m;
      s4_q       <= qr_c[F +: UW];
      s4_lit     <= s3_lit;
      s4_gray    <= s3_gray;
      s4_alp     <= s3_alp;
      s4_gray_en <= s3_gray_en;
    end
  end

  // stage 5: p = 2l - q and span d = q - p = 2q - 2l
  logic [NUM_CH-1:0][UW-1:0] s5_m;
  logic [UW-1:0]             s5_p, s5_d;
  chan_t                     s5_gray, s5_alp;
  logic                      s5_gray_en;
  logic [UW:0]               p_c, d_c;

  always_comb begin
    p_c = {s4_lit, 1'b0} - {1'b0, s4_q};
    d_c = {s4_q, 1'b0} - {s4_lit, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_m       <= s4_m;
      s5_p       <= p_c[UW-1:0];
      s5_d       <= d_c[UW-1:0];
      s5_gray    <= s4_gray;
      s5_alp     <= s4_alp;
      s5_gray_en <= s4_gray_en;
    end
  end

  // stage 6: span times slope for each channel
  logic [NUM_CH-1:0][PW-1:0] s6_prod;
  logic [UW-1:0]             s6_p;
  chan_t                     s6_gray, s6_alp;
  logic                      s6_gray_en;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s6_prod[c] <= PW'(s5_d) * PW'(s5_m[c]);
      end
      s6_p       <= s5_p;
      s6_gray    <= s5_gray;
      s6_alp     <= s5_alp;
      s6_gray_en <= s5_gray_en;
    end
  end

  // stage 7: channel value at 2F fraction bits
  logic [NUM_CH-1:0][PW-1:0] s7_v2;
  chan_t                     s7_gray, s7_alp;
  logic                      s7_gray_en;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s7_v2[c] <= (PW'(s6_p) << F) + s6_prod[c];
      end
      s7_gray    <= s6_gray;
      s7_alp     <= s6_alp;
      s7_gray_en <= s6_gray_en;
    end
  end

  // stage 8: scale by 255, round half up, clamp or use gray; output register
  logic [NUM_CH-1:0][YW-1:0] y_c;
  chan_t [NUM_CH-1:0]        ch_c;
  chan_t                     red_q, green_q, blue_q, alpha_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      y_c[c]  = (YW'(s7_v2[c]) << CHAN_W) - YW'(s7_v2[c]) + HALF_Y;
      ch_c[c] = s7_gray_en ? s7_gray : clamp_chan(y_c[c][2*F +: CHAN_W+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      red_q   <= ch_c[CH_RED];
      green_q <= ch_c[CH_GREEN];
      blue_q  <= ch_c[CH_BLUE];
      alpha_q <= s7_alp;
    end
  end

  assign rgba_out.valid     = vld[NSTG-1];
  assign rgba_out.red       = red_q;
  assign rgba_out.green     = green_q;
  assign rgba_out.blue      = blue_q;
  assign rgba_out.alpha_out = alpha_q;

endmodule

### hdl/hslrgba_chk.sv
// port-level assertion checker for the hsl to rgba converter, with its bind
`timescale 1ns / 1ps

module hslrgba_chk
  import hslrgba_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input chan_t red,
  input chan_t green,
  input chan_t blue,
  input chan_t alpha_out
);

  // a stalled result item keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(alpha_out))
    else $error("stalled result item changed");

  // nothing comes out right after reset
  assert property (@(posedge clk) $fell(rst) |-> !out_valid)
    else $error("result item valid right after reset");

  // a draining output never back-pressures the input
  assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // with no stall an accepted item comes out at the output
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind hsl_to_rgba_converter hslrgba_chk u_hslrgba_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (hsl_in.valid),
  .in_ready  (hsl_in.ready),
  .out_valid (rgba_out.valid),
  .out_ready (rgba_out.ready),
  .red       (rgba_out.red),
  .green     (rgba_out.green),
  .blue      (rgba_out.blue),
  .alpha_out (rgba_out.alpha_out)
);
